### hdl/npc_pkg.sv
// Package for the nearest palette color block: field widths, codes, sequencer
// state type and the channel difference function. No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package npc_pkg;

    localparam int COLOR_W    = 8;
    localparam int INDEX_W    = 8;
    localparam int COUNT_W    = 9;
    localparam int LIMIT_W    = 10;
    localparam int ENTRY_W    = 3 * COLOR_W;
    localparam int CFG_ADDR_W = 1;
    localparam int CFG_DATA_W = 10;
    localparam int MAX_SCAN   = 256;

    localparam logic [COUNT_W-1:0] COLORS_RESET = 9'd256;
    localparam logic [LIMIT_W-1:0] LIMIT_RESET  = 10'd384;

    localparam logic ACT_WRITE = 1'b0;
    localparam logic ACT_QUERY = 1'b1;

    localparam logic [CFG_ADDR_W-1:0] CFG_COLORS_IN_USE  = 1'd0;
    localparam logic [CFG_ADDR_W-1:0] CFG_DISTANCE_LIMIT = 1'd1;

    typedef enum logic {
        ST_IDLE,
        ST_SCAN
    } t_state;

    function automatic logic [COLOR_W-1:0] abs_diff(input logic [COLOR_W-1:0] a,
                                                    input logic [COLOR_W-1:0] b);
        return (a > b) ? (a - b) : (b - a);
    endfunction

endpackage

`default_nettype wire

### hdl/nearest_palette_color.sv
// Nearest palette color search: palette RAM, scan sequencer and distance unit.
// Depends on npc_pkg and npc_ram.
//
// A write request (action 0) stores one palette entry in the cycle it is
// accepted and gives no result; busy stays low. A query request (action 1)
// scans entries 0 to N-1, N = min(colors_in_use, palette depth, 256), one
// entry per cycle through the palette RAM's single registered read port and
// one shared sum-of-absolute-differences unit. Busy stays high while the scan runs,
// up to the first exact match or to entry N-1, and the result strobe o_valid is
// high for a single cycle from the edge at which busy falls.
// With N = 0 the result (index 0) appears in the cycle after acceptance and
// busy never rises. The result is shown for exactly one cycle: the receiver
// cannot stall it.
`timescale 1ns / 1ps
`default_nettype none

module nearest_palette_color #(
    parameter int PALETTE_DEPTH = 256
) (
    input  wire                                 i_clk,
    input  wire                                 i_rst_n,
    input  wire                                 start,
    output logic                                busy,
    input  wire                                 i_action,
    input  wire  [npc_pkg::INDEX_W-1:0]         i_entry_index,
    input  wire  [npc_pkg::COLOR_W-1:0]         i_red,
    input  wire  [npc_pkg::COLOR_W-1:0]         i_green,
    input  wire  [npc_pkg::COLOR_W-1:0]         i_blue,
    input  wire                                 i_cfg_we,
    input  wire  [npc_pkg::CFG_ADDR_W-1:0]      i_cfg_addr,
    input  wire  [npc_pkg::CFG_DATA_W-1:0]      i_cfg_wdata,
    output logic                                o_valid,
    output logic [npc_pkg::INDEX_W-1:0]         o_best_index
);

    import npc_pkg::*;

    localparam int STORE_DEPTH = (PALETTE_DEPTH < MAX_SCAN) ? PALETTE_DEPTH : MAX_SCAN;
    localparam int ADDR_W      = $clog2(STORE_DEPTH);
    localparam int CNT_W       = $clog2(STORE_DEPTH + 1);

    t_state               r_state, n_state;
    logic [COUNT_W-1:0]   r_colors;
    logic [LIMIT_W-1:0]   r_dist_limit;
    logic [COLOR_W-1:0]   r_red, r_green, r_blue;
    logic [CNT_W-1:0]     r_count, n_count;
    logic [CNT_W-1:0]     r_rd_cnt, n_rd_cnt;
    logic                 r_pend, n_pend;
    logic [ADDR_W-1:0]    r_pend_idx, n_pend_idx;
    logic [LIMIT_W-1:0]   r_limit, n_limit;
    logic [ADDR_W-1:0]    r_best, n_best;
    logic                 r_valid, n_valid;
    logic [ADDR_W-1:0]    r_out, n_out;

    logic                 accept, ram_we;
    logic [ENTRY_W-1:0]   rd_data;
    logic [LIMIT_W-1:0]   distance;
    logic                 exact, hit, last;
    logic [COUNT_W-1:0]   clamped;

    assign accept = start && (r_state == ST_IDLE);
    assign ram_we = accept && (i_action == ACT_WRITE)
                    && ({1'b0, i_entry_index} < COUNT_W'(STORE_DEPTH));

    npc_ram #(
        .WIDTH(ENTRY_W),
        .DEPTH(STORE_DEPTH)
    ) u_palette (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (i_entry_index[ADDR_W-1:0]),
        .i_wdata ({i_red, i_green, i_blue}),
        .i_raddr (r_rd_cnt[ADDR_W-1:0]),
        .o_rdata (rd_data)
    );

    assign distance = LIMIT_W'(abs_diff(rd_data[3*COLOR_W-1:2*COLOR_W], r_red))
                    + LIMIT_W'(abs_diff(rd_data[2*COLOR_W-1:COLOR_W], r_green))
                    + LIMIT_W'(abs_diff(rd_data[COLOR_W-1:0], r_blue));
    assign exact = (distance == '0);
    assign hit   = (distance < r_limit);
    assign last  = ((CNT_W'(r_pend_idx) + CNT_W'(1)) == r_count);

    assign clamped = (r_colors > COUNT_W'(STORE_DEPTH)) ? COUNT_W'(STORE_DEPTH) : r_colors;

    always_comb begin
        n_state    = r_state;
        n_count    = r_count;
        n_rd_cnt   = r_rd_cnt;
        n_pend     = 1'b0;
        n_pend_idx = r_pend_idx;
        n_limit    = r_limit;
        n_best     = r_best;
        n_valid    = 1'b0;
        n_out      = r_out;
        case (r_state)
            ST_IDLE: begin
                if (accept && (i_action == ACT_QUERY)) begin
                    n_count  = CNT_W'(clamped);
                    n_rd_cnt = '0;
                    n_limit  = r_dist_limit;
                    n_best   = '0;
                    if (clamped == '0) begin
                        n_valid = 1'b1;
                        n_out   = '0;
                    end else begin
                        n_state = ST_SCAN;
                    end
                end
            end
            ST_SCAN: begin
                if (r_rd_cnt < r_count) begin
                    n_pend     = 1'b1;
                    n_pend_idx = r_rd_cnt[ADDR_W-1:0];
                    n_rd_cnt   = r_rd_cnt + CNT_W'(1);
                end
                if (r_pend) begin
                    if (hit || exact) begin
                        n_limit = distance;
                        n_best  = r_pend_idx;
                    end
                    if (exact || last) begin
                        n_valid = 1'b1;
                        n_out   = (hit || exact) ? r_pend_idx : r_best;
                        n_pend  = 1'b0;
                        n_state = ST_IDLE;
                    end
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= ST_IDLE;
            r_pend       <= 1'b0;
            r_valid      <= 1'b0;
            r_rd_cnt     <= '0;
            r_count      <= '0;
            r_limit      <= '0;
            r_colors     <= COLORS_RESET;
            r_dist_limit <= LIMIT_RESET;
        end else begin
            r_state  <= n_state;
            r_pend   <= n_pend;
            r_valid  <= n_valid;
            r_rd_cnt <= n_rd_cnt;
            r_count  <= n_count;
            r_limit  <= n_limit;
            if (i_cfg_we) begin
                case (i_cfg_addr)
                    CFG_COLORS_IN_USE:  r_colors     <= i_cfg_wdata[COUNT_W-1:0];
                    CFG_DISTANCE_LIMIT: r_dist_limit <= i_cfg_wdata[LIMIT_W-1:0];
                    default: begin
                    end
                endcase
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_pend_idx <= n_pend_idx;
        r_best     <= n_best;
        r_out      <= n_out;
        if (accept) begin
            r_red   <= i_red;
            r_green <= i_green;
            r_blue  <= i_blue;
        end
    end

    assign busy         = (r_state != ST_IDLE);
    assign o_valid      = r_valid;
    assign o_best_index = INDEX_W'(r_out);

    a_valid_when_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> !busy)
        else $error("result strobe while scanning");

    a_pend_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (busy && r_pend) |-> (CNT_W'(r_pend_idx) < r_count))
        else $error("examined entry beyond search count");

    a_issue_bounded: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        busy |-> (r_rd_cnt <= r_count))
        else $error("read issued beyond search count");

    a_limit_falls: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (busy && $past(busy)) |-> (r_limit <= $past(r_limit)))
        else $error("running limit increased during scan");

    a_scan_nonempty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(busy) |-> (r_count != '0))
        else $error("scan started with empty search count");

endmodule

`default_nettype wire

### hdl/npc_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

module npc_ram #(
    parameter int WIDTH = 24,
    parameter int DEPTH = 256
) (
    input  wire                     i_clk,
    input  wire                     i_we,
    input  wire [$clog2(DEPTH)-1:0] i_waddr,
    input  wire [WIDTH-1:0]         i_wdata,
    input  wire [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]        o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end

endmodule

`default_nettype wire

### tb/tb_top.sv
// Self-checking testbench for nearest_palette_color: palette writes and nearest
// color queries are driven through start/busy and checked against a palette mirror.
// Depends on npc_pkg and the nearest_palette_color RTL.
`timescale 1ns / 1ps

module tb_top;

    import npc_pkg::*;

    typedef struct packed {
        logic               act;
        logic [INDEX_W-1:0] slot;
        logic [COLOR_W-1:0] r;
        logic [COLOR_W-1:0] g;
        logic [COLOR_W-1:0] b;
    } t_pal_req;

    logic                  i_clk = 1'b0;
    logic                  i_rst_n;
    logic                  start;
    logic                  busy;
    logic                  i_action;
    logic [INDEX_W-1:0]    i_entry_index;
    logic [COLOR_W-1:0]    i_red;
    logic [COLOR_W-1:0]    i_green;
    logic [COLOR_W-1:0]    i_blue;
    logic                  i_cfg_we;
    logic [CFG_ADDR_W-1:0] i_cfg_addr;
    logic [CFG_DATA_W-1:0] i_cfg_wdata;
    logic                  o_valid;
    logic [INDEX_W-1:0]    o_best_index;

    nearest_palette_color DUT (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .start         (start),
        .busy          (busy),
        .i_action      (i_action),
        .i_entry_index (i_entry_index),
        .i_red         (i_red),
        .i_green       (i_green),
        .i_blue        (i_blue),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_addr    (i_cfg_addr),
        .i_cfg_wdata   (i_cfg_wdata),
        .o_valid       (o_valid),
        .o_best_index  (o_best_index)
    );

    always #4 i_clk = ~i_clk;

    t_pal_req           pend_q[$];
    logic [INDEX_W-1:0] best_q[$];
    logic [ENTRY_W-1:0] pal_mirror [MAX_SCAN];
    logic [ENTRY_W-1:0] gen_pal [MAX_SCAN];
    logic               gen_written [MAX_SCAN];
    logic [COUNT_W-1:0] scan_colors;
    logic [LIMIT_W-1:0] dist_cap;
    int                 reqs_pushed;
    int                 reqs_taken;
    int                 err_cnt;
    int                 burst_left;
    int                 gap_left;
    logic               req_taken;
    t_pal_req           nxt;

    function automatic int chan_gap(input int a, input int b);
        return (a > b) ? a - b : b - a;
    endfunction

    function automatic logic [INDEX_W-1:0] nearest_index(input logic [COLOR_W-1:0] r,
                                                         input logic [COLOR_W-1:0] g,
                                                         input logic [COLOR_W-1:0] b);
        int span;
        int cap;
        int best;
        int d;
        span = (scan_colors > MAX_SCAN) ? MAX_SCAN : int'(scan_colors);
        cap  = int'(dist_cap);
        best = 0;
        for (int k = 0; k < span; k++) begin
            d = chan_gap(int'(pal_mirror[k][23:16]), int'(r))
              + chan_gap(int'(pal_mirror[k][15:8]), int'(g))
              + chan_gap(int'(pal_mirror[k][7:0]), int'(b));
            if (d == 0) begin
                best = k;
                break;
            end
            if (d < cap) begin
                cap  = d;
                best = k;
            end
        end
        return best[INDEX_W-1:0];
    endfunction

    function automatic logic [COLOR_W-1:0] nudge(input logic [COLOR_W-1:0] c);
        int v;
        v = int'(c) + int'($urandom_range(0, 6)) - 3;
        if (v < 0) v = 0;
        if (v > 255) v = 255;
        return v[COLOR_W-1:0];
    endfunction

    function automatic logic [COLOR_W-1:0] extreme_chan();
        return $urandom_range(0, 1) ? 8'hFF : 8'h00;
    endfunction

    task automatic push_req(input logic act, input logic [INDEX_W-1:0] slot,
                            input logic [COLOR_W-1:0] r, input logic [COLOR_W-1:0] g,
                            input logic [COLOR_W-1:0] b);
        pend_q.push_back('{act, slot, r, g, b});
        reqs_pushed++;
        if (act == ACT_WRITE) begin
            gen_pal[slot]     = {r, g, b};
            gen_written[slot] = 1'b1;
        end
    endtask

    task automatic wait_idle();
        while (reqs_taken != reqs_pushed || best_q.size() != 0) @(negedge i_clk);
        repeat (4) @(negedge i_clk);
    endtask

    task automatic cfg_write(input logic [CFG_ADDR_W-1:0] addr,
                             input logic [CFG_DATA_W-1:0] data);
        @(negedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_addr  <= addr;
        i_cfg_wdata <= data;
        if (addr == CFG_COLORS_IN_USE) scan_colors = data[COUNT_W-1:0];
        else dist_cap = data[LIMIT_W-1:0];
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    task automatic fill_prefix();
        int span;
        span = (scan_colors > MAX_SCAN) ? MAX_SCAN : int'(scan_colors);
        for (int k = 0; k < span; k++)
            if (!gen_written[k])
                push_req(ACT_WRITE, k[INDEX_W-1:0], COLOR_W'($urandom), COLOR_W'($urandom),
                         COLOR_W'($urandom));
    endtask

    task automatic rand_phase(input int n_items);
        int                 span;
        int                 sel;
        logic [ENTRY_W-1:0] e;
        logic [INDEX_W-1:0] slot;
        span = (scan_colors > MAX_SCAN) ? MAX_SCAN : int'(scan_colors);
        for (int i = 0; i < n_items; i++) begin
            sel = $urandom_range(0, 9);
            if (span > 0 && sel < 7) e = gen_pal[$urandom_range(0, span - 1)];
            else e = ENTRY_W'($urandom);
            if ($urandom_range(0, 99) < 55) begin
                if (span > 0 && sel >= 4 && sel < 7)
                    e = {nudge(e[23:16]), nudge(e[15:8]), nudge(e[7:0])};
                else if (sel == 9)
                    e = {extreme_chan(), extreme_chan(), extreme_chan()};
                push_req(ACT_QUERY, INDEX_W'($urandom), e[23:16], e[15:8], e[7:0]);
            end else begin
                slot = (span > 0 && $urandom_range(0, 3) != 0)
                       ? INDEX_W'($urandom_range(0, span - 1)) : INDEX_W'($urandom);
                if (sel >= 3 && sel < 8) e = ENTRY_W'($urandom);
                else if (sel >= 8) e = {extreme_chan(), extreme_chan(), extreme_chan()};
                push_req(ACT_WRITE, slot, e[23:16], e[15:8], e[7:0]);
            end
        end
    endtask

    // Result check first, then take the new request
    always @(posedge i_clk) begin
        req_taken <= i_rst_n && start && !busy;
        if (i_rst_n) begin
            if (o_valid) begin
                if (best_q.size() == 0) begin
                    err_cnt++;
                    if (err_cnt <= 10) $display("unexpected result: best_index %0d", o_best_index);
                end else begin
                    if (o_best_index !== best_q[0]) begin
                        err_cnt++;
                        if (err_cnt <= 10)
                            $display("best_index mismatch: expected %0d, actual %0d",
                                     best_q[0], o_best_index);
                    end
                    void'(best_q.pop_front());
                end
            end
            if (start && !busy) begin
                reqs_taken++;
                if (i_action == ACT_WRITE) pal_mirror[i_entry_index] = {i_red, i_green, i_blue};
                else best_q.push_back(nearest_index(i_red, i_green, i_blue));
            end
        end
    end

    // Hold the request until taken, then advance in bursts with random gaps
    always @(negedge i_clk) begin
        if (i_rst_n && (!start || req_taken)) begin
            if (gap_left > 0 || pend_q.size() == 0) begin
                if (gap_left > 0) gap_left--;
                start <= 1'b0;
            end else begin
                nxt = pend_q.pop_front();
                i_action      <= nxt.act;
                i_entry_index <= nxt.slot;
                i_red         <= nxt.r;
                i_green       <= nxt.g;
                i_blue        <= nxt.b;
                start         <= 1'b1;
                if (burst_left > 1) begin
                    burst_left--;
                end else if ($urandom_range(0, 7) == 0) begin
                    burst_left = 300;
                    gap_left   = 0;
                end else begin
                    burst_left = $urandom_range(1, 24);
                    gap_left   = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 8);
                end
            end
        end
    end

    initial begin
        int colors_tab [10] = '{16, 1, 256, 2, 40, 1023, 7, 300, 100, 255};
        int limit_tab  [10] = '{766, 0, 384, 1, 50, 1023, 200, 766, 10, 2};
        i_rst_n       = 1'b0;
        start         = 1'b0;
        i_action      = ACT_WRITE;
        i_entry_index = '0;
        i_red         = '0;
        i_green       = '0;
        i_blue        = '0;
        i_cfg_we      = 1'b0;
        i_cfg_addr    = CFG_COLORS_IN_USE;
        i_cfg_wdata   = '0;
        req_taken     = 1'b0;
        reqs_pushed   = 0;
        reqs_taken    = 0;
        err_cnt       = 0;
        burst_left    = 0;
        gap_left      = 0;
        scan_colors   = COLORS_RESET;
        dist_cap      = LIMIT_RESET;
        for (int k = 0; k < MAX_SCAN; k++) begin
            pal_mirror[k]  = '0;
            gen_pal[k]     = '0;
            gen_written[k] = 1'b0;
        end
        repeat (12) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Empty search, palette extremes and a duplicated entry
        cfg_write(CFG_COLORS_IN_USE, 10'd0);
        push_req(ACT_QUERY, 8'hFF, 8'hFF, 8'h00, 8'hFF);
        push_req(ACT_QUERY, 8'h00, 8'h00, 8'h00, 8'h00);
        push_req(ACT_WRITE, 8'd0, 8'h00, 8'h00, 8'h00);
        push_req(ACT_WRITE, 8'd1, 8'hFF, 8'hFF, 8'hFF);
        push_req(ACT_WRITE, 8'd2, 8'd10, 8'd20, 8'd30);
        push_req(ACT_WRITE, 8'd3, 8'd10, 8'd20, 8'd30);
        push_req(ACT_WRITE, 8'd255, 8'hAA, 8'h55, 8'hAA);
        wait_idle();
        cfg_write(CFG_COLORS_IN_USE, 10'd4);
        cfg_write(CFG_DISTANCE_LIMIT, 10'd766);
        push_req(ACT_QUERY, 8'd0, 8'd10, 8'd20, 8'd30);
        push_req(ACT_QUERY, 8'd0, 8'hFF, 8'hFF, 8'hFF);
        push_req(ACT_QUERY, 8'd0, 8'h00, 8'h00, 8'h00);
        push_req(ACT_QUERY, 8'd0, 8'd12, 8'd20, 8'd30);
        push_req(ACT_QUERY, 8'd0, 8'd128, 8'd128, 8'd128);
        push_req(ACT_QUERY, 8'd0, 8'd200, 8'd100, 8'd50);
        wait_idle();
        cfg_write(CFG_DISTANCE_LIMIT, 10'd0);
        push_req(ACT_QUERY, 8'd0, 8'd12, 8'd20, 8'd30);
        push_req(ACT_QUERY, 8'd0, 8'hFF, 8'hFF, 8'hFF);
        push_req(ACT_QUERY, 8'd0, 8'd10, 8'd20, 8'd30);
        wait_idle();
        cfg_write(CFG_COLORS_IN_USE, 10'd1);
        cfg_write(CFG_DISTANCE_LIMIT, 10'd1);
        push_req(ACT_QUERY, 8'd0, 8'd1, 8'd0, 8'd0);
        push_req(ACT_QUERY, 8'd0, 8'hFF, 8'hFF, 8'hFF);

        for (int p = 0; p < 10; p++) begin
            wait_idle();
            cfg_write(CFG_COLORS_IN_USE, CFG_DATA_W'(colors_tab[p]));
            cfg_write(CFG_DISTANCE_LIMIT, CFG_DATA_W'(limit_tab[p]));
            fill_prefix();
            rand_phase(160);
        end

        while (reqs_taken != reqs_pushed || best_q.size() != 0) @(posedge i_clk);
        repeat (20) @(posedge i_clk);
        err_cnt += best_q.size();
        if (err_cnt == 0) begin
            $display("[nearest_palette_color] OK");
        end else begin
            $display("[nearest_palette_color] ERROR");
        end
        $finish;
    end

    initial begin
        #20_000_000;
        $display("[nearest_palette_color] ERROR");
        $finish;
    end

endmodule
